[rtl/hbr_pkg.sv]
// Package for the HID boot report decoder: report and event payload types,
// the job record passed from front end to back end, and the fixed codes.
// Used by every module of the block; depends on nothing.
package hbr_pkg;

  // Report layout.
  localparam int ReportBytes = 8;
  localparam int SlotBase    = 2;
  localparam int AvailSlots  = 6;

  // Event mask positions inside a job.
  localparam int ModBase    = 0;
  localparam int RelBase    = 8;
  localparam int PressBase  = RelBase + AvailSlots;
  localparam int MaskBits   = PressBase + AvailSlots;
  localparam int MaskIdxW   = $clog2(MaskBits);
  localparam int MouseX     = 3;
  localparam int MouseY     = 4;
  localparam int MouseWheel = 5;
  localparam int MouseBtns  = 3;

  // Usages and codes.
  localparam logic [7:0] RolloverUsage = 8'h01;
  localparam logic [8:0] ModUsageBase  = 9'h0E0;
  localparam logic [8:0] CodeBtnLeft   = 9'h110;
  localparam logic [8:0] CodeRelX      = 9'd0;
  localparam logic [8:0] CodeRelY      = 9'd1;
  localparam logic [8:0] CodeRelWheel  = 9'd8;

  // Event types.
  localparam logic [1:0] EvSync = 2'd0;
  localparam logic [1:0] EvKey  = 2'd1;
  localparam logic [1:0] EvRel  = 2'd2;

  // Configuration port.
  localparam int         CfgAddrW   = 3;
  localparam logic [0:0] RegIdxMode = 1'b0;

  typedef struct packed {
    logic [7:0] report_byte_0;
    logic [7:0] report_byte_1;
    logic [7:0] report_byte_2;
    logic [7:0] report_byte_3;
    logic [7:0] report_byte_4;
    logic [7:0] report_byte_5;
    logic [7:0] report_byte_6;
    logic [7:0] report_byte_7;
    logic [6:0] report_length;
  } report_t;

  typedef struct packed {
    logic [1:0]        event_type;
    logic [8:0]        event_code;
    logic signed [7:0] event_value;
    logic              last_of_burst;
  } event_t;

  // One classified report: which events to emit and the bytes they need.
  typedef struct packed {
    logic                             kbd;
    logic [MaskBits-1:0]              mask;
    logic [ReportBytes-1:0][7:0]      bytes;
    logic [AvailSlots-1:0][7:0]       prev_slots;
  } job_t;

endpackage

[rtl/hbr_front.sv]
// Front end of the HID boot report decoder: accepts reports, compares them
// with the stored previous report and builds a job with an event mask.
// Depends on hbr_pkg.
module hbr_front #(
  parameter int KEY_SLOTS = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            mode_kbd,
  input  logic            rpt_valid,
  output logic            rpt_stall,
  input  hbr_pkg::report_t rpt,
  input  logic            q_full,
  output logic            q_push,
  output hbr_pkg::job_t   q_job
);
  import hbr_pkg::*;

  localparam int NSlots = (KEY_SLOTS > AvailSlots) ? AvailSlots : KEY_SLOTS;

  logic [7:0]             prev_mods;
  logic [NSlots-1:0][7:0] prev_slot;
  logic [7:0]             prev_buttons;

  logic [ReportBytes-1:0][7:0] rb;
  logic                        rollover;
  logic                        kbd_ok;
  logic                        mouse_ok;
  logic                        accept;
  logic [MaskBits-1:0]         kbd_mask;
  logic [MaskBits-1:0]         mouse_mask;
  logic                        seen;

  assign rb = {rpt.report_byte_7, rpt.report_byte_6, rpt.report_byte_5,
               rpt.report_byte_4, rpt.report_byte_3, rpt.report_byte_2,
               rpt.report_byte_1, rpt.report_byte_0};

  assign rpt_stall = q_full;
  assign accept    = rpt_valid && !rpt_stall;

  // Keyboard comparison: modifier changes, released and pressed slots.
  always_comb begin
    rollover = 1'b0;
    kbd_mask = '0;
    seen     = 1'b0;
    for (int s = 0; s < NSlots; s++) begin
      if (rb[SlotBase+s] == RolloverUsage) rollover = 1'b1;
    end
    kbd_mask[ModBase +: 8] = prev_mods ^ rb[0];
    for (int s = 0; s < NSlots; s++) begin
      seen = 1'b0;
      for (int t = 0; t < NSlots; t++) begin
        if (rb[SlotBase+t] == prev_slot[s]) seen = 1'b1;
      end
      kbd_mask[RelBase+s] = (prev_slot[s] != 8'd0) && !seen;
      seen = 1'b0;
      for (int t = 0; t < NSlots; t++) begin
        if (prev_slot[t] == rb[SlotBase+s]) seen = 1'b1;
      end
      kbd_mask[PressBase+s] = (rb[SlotBase+s] != 8'd0) && !seen;
    end
    kbd_ok = (rpt.report_length >= 7'(ReportBytes)) && !rollover;
  end

  // Mouse comparison: button changes and nonzero deltas.
  always_comb begin
    mouse_mask                       = '0;
    mouse_mask[MouseBtns-1:0]        = rb[0][MouseBtns-1:0] ^ prev_buttons[MouseBtns-1:0];
    mouse_mask[MouseX]               = rb[1] != 8'd0;
    mouse_mask[MouseY]               = rb[2] != 8'd0;
    mouse_mask[MouseWheel]           = (rpt.report_length > 7'd3) && (rb[3] != 8'd0);
    mouse_ok                         = rpt.report_length >= 7'd3;
  end

  // Job record and the push into the queue.
  always_comb begin
    q_job            = '0;
    q_job.kbd        = mode_kbd;
    q_job.mask       = mode_kbd ? kbd_mask : mouse_mask;
    q_job.bytes      = rb;
    for (int s = 0; s < NSlots; s++) begin
      q_job.prev_slots[s] = prev_slot[s];
    end
    q_push = accept && (mode_kbd ? kbd_ok : mouse_ok) && (q_job.mask != '0);
  end

  // Stored previous reports, one per mode.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_mods    <= '0;
      prev_slot    <= '0;
      prev_buttons <= '0;
    end else if (accept) begin
      if (mode_kbd && kbd_ok) begin
        prev_mods <= rb[0];
        for (int s = 0; s < NSlots; s++) begin
          prev_slot[s] <= rb[SlotBase+s];
        end
      end else if (!mode_kbd && mouse_ok) begin
        prev_buttons <= rb[0];
      end
    end
  end

endmodule

[rtl/hbr_queue.sv]
// Two-entry job queue between the front end and the back end of the HID
// boot report decoder. Depends on hbr_pkg.
module hbr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hbr_pkg::job_t din,
  input  logic          pop,
  output hbr_pkg::job_t dout,
  output logic          full,
  output logic          empty
);
  import hbr_pkg::*;

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign dout  = mem[rd_ptr];

  // Storage; entries need no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/hbr_back.sv]
// Back end of the HID boot report decoder: takes jobs from the queue and
// emits one event per cycle, when not stalled, into a registered output;
// each job closes with a sync. Depends on hbr_pkg.
module hbr_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  hbr_pkg::job_t   q_job,
  output logic            q_pop,
  output logic            evt_valid,
  input  logic            evt_stall,
  output hbr_pkg::event_t evt
);
  import hbr_pkg::*;

  job_t                cur;
  logic [MaskBits-1:0] rem;
  logic                active;

  logic                advance;
  logic                emit;
  logic [MaskIdxW-1:0] idx;
  logic [2:0]          slot_idx;
  logic [2:0]          byte_idx;
  event_t              ev;

  assign advance = !evt_valid || !evt_stall;
  assign emit    = advance && active;
  assign q_pop   = !q_empty && (!active || (emit && (rem == '0)));

  // Lowest pending event of the current job.
  always_comb begin
    idx = '0;
    for (int i = MaskBits - 1; i >= 0; i--) begin
      if (rem[i]) idx = MaskIdxW'(i);
    end
    slot_idx = 3'(idx - MaskIdxW'(RelBase));
    byte_idx = 3'(idx - MaskIdxW'(PressBase - SlotBase));
  end

  // Event for that position, or the closing sync.
  always_comb begin
    ev = '0;
    if (rem == '0) begin
      ev.event_type    = EvSync;
      ev.last_of_burst = 1'b1;
    end else if (cur.kbd) begin
      ev.event_type = EvKey;
      if (idx < MaskIdxW'(RelBase)) begin
        ev.event_code  = ModUsageBase | {6'd0, idx[2:0]};
        ev.event_value = {7'd0, cur.bytes[0][idx[2:0]]};
      end else if (idx < MaskIdxW'(PressBase)) begin
        ev.event_code  = {1'b0, cur.prev_slots[slot_idx]};
        ev.event_value = 8'sd0;
      end else begin
        ev.event_code  = {1'b0, cur.bytes[byte_idx]};
        ev.event_value = 8'sd1;
      end
    end else begin
      case (idx)
        MaskIdxW'(MouseX): begin
          ev.event_type  = EvRel;
          ev.event_code  = CodeRelX;
          ev.event_value = $signed(cur.bytes[1]);
        end
        MaskIdxW'(MouseY): begin
          ev.event_type  = EvRel;
          ev.event_code  = CodeRelY;
          ev.event_value = $signed(cur.bytes[2]);
        end
        MaskIdxW'(MouseWheel): begin
          ev.event_type  = EvRel;
          ev.event_code  = CodeRelWheel;
          ev.event_value = $signed(cur.bytes[3]);
        end
        default: begin
          ev.event_type  = EvKey;
          ev.event_code  = CodeBtnLeft + {7'd0, idx[1:0]};
          ev.event_value = {7'd0, cur.bytes[0][idx[1:0]]};
        end
      endcase
    end
  end

  // Job register and pending mask.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (q_pop) begin
      active <= 1'b1;
    end else if (emit && (rem == '0)) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
      rem <= q_job.mask;
    end else if (emit) begin
      rem[idx] <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (advance) begin
      evt_valid <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      evt <= ev;
    end
  end

endmodule

[rtl/hid_boot_report_to_events.sv]
// Top level of the HID boot report decoder: configuration register, front
// end, job queue and back end. Depends on hbr_pkg, hbr_front, hbr_queue, hbr_back.
//
//   Channel   Direction  Handshake            Payload
//   rpt       in         rpt_valid/rpt_stall  report_t, one boot report
//   evt       out        evt_valid/evt_stall  event_t, one input event
//   APB       in         psel/penable/pready  mode register at address 0
//
// A report that causes N key, button or motion events yields N + 1 event
// transactions (the last is the sync), one per cycle from the back end while
// evt_stall is low; a keyboard report yields up to 21, a mouse report up to 7.
// Reports are accepted every cycle while the two-entry job queue has room;
// a report that causes no event never enters the queue.
// Reset is synchronous: stored reports clear and the mode returns to keyboard.
// A stalled event holds in the output register; the front end keeps taking
// reports until the queue fills.
module hid_boot_report_to_events #(
  parameter int KEY_SLOTS = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rpt_valid,
  output logic                          rpt_stall,
  input  hbr_pkg::report_t              rpt,
  output logic                          evt_valid,
  input  logic                          evt_stall,
  output hbr_pkg::event_t               evt,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hbr_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import hbr_pkg::*;

  logic mode_kbd;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  job_t q_in;
  job_t q_out;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegIdxMode) ? {31'd0, mode_kbd} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_kbd <= 1'b1;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegIdxMode)) begin
      mode_kbd <= pwdata[0];
    end
  end

  hbr_front #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .mode_kbd  (mode_kbd),
    .rpt_valid (rpt_valid),
    .rpt_stall (rpt_stall),
    .rpt       (rpt),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_in)
  );

  hbr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .pop   (q_pop),
    .dout  (q_out),
    .full  (q_full),
    .empty (q_empty)
  );

  hbr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_job     (q_out),
    .q_pop     (q_pop),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt)
  );

endmodule

[rtl/hbr_checker.sv]
// Port-level checks for the HID boot report decoder, bound to the top level.
// Depends on hbr_pkg and hid_boot_report_to_events.
module hbr_checker (
  input logic            clk,
  input logic            rst,
  input logic            evt_valid,
  input logic            evt_stall,
  input hbr_pkg::event_t evt
);
  import hbr_pkg::*;

  // A stalled event transaction holds.
  a_evt_hold: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_stall |=> evt_valid && $stable(evt))
    else $error("event changed while stalled");

  // A sync event carries zero code and value and closes the burst.
  a_sync_form: assert property (@(posedge clk) disable iff (rst)
    evt_valid && (evt.event_type == EvSync) |->
      (evt.event_code == 9'd0) && (evt.event_value == 8'sd0) && evt.last_of_burst)
    else $error("malformed sync event");

  // Only the sync event closes a burst.
  a_last_is_sync: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt.last_of_burst |-> evt.event_type == EvSync)
    else $error("burst closed by a non-sync event");

  // No event is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !evt_valid)
    else $error("event offered after reset");

endmodule

bind hid_boot_report_to_events hbr_checker u_hbr_checker (
  .clk       (clk),
  .rst       (rst),
  .evt_valid (evt_valid),
  .evt_stall (evt_stall),
  .evt       (evt)
);

[sim/tb_hid_boot_report_to_events.sv]
// Self-checking testbench for hid_boot_report_to_events: drives boot reports in
// keyboard and mouse mode and checks every event against its own decoder.
// Depends on hbr_pkg and the RTL of the block; needs no files or arguments.
module tb_hid_boot_report_to_events;
  timeunit 1ns;
  timeprecision 1ps;

  import hbr_pkg::*;

  localparam int KeySlots    = 6;
  localparam int SlotsUsed   = (KeySlots > AvailSlots) ? AvailSlots : KeySlots;
  localparam int MouseMinLen = 3;
  localparam int DrainCycles = 8;
  localparam int CycleLimit  = 2000000;
  localparam int MaxReported = 10;
  localparam logic [CfgAddrW-1:0] ModeRegAddr = CfgAddrW'(RegIdxMode) << 2;
  localparam logic [7:0] EmptySlot = 8'h00;

  typedef logic [ReportBytes-1:0][7:0] report_bytes_t;

  // Clock, reset and all block inputs start at known values.
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        rpt_valid = 1'b0;
  logic        rpt_stall;
  report_t     rpt       = '0;
  logic        evt_valid;
  logic        evt_stall = 1'b0;
  event_t      evt;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shared between stimulus, driver and monitor.
  report_t     report_queue[$];
  event_t      predicted_events[$];
  bit          idle_on = 1'b1;
  int          cycle_count = 0;
  int          mismatch_count = 0;
  int          events_checked = 0;
  int          keyboard_reports = 0;
  int          mouse_reports = 0;
  int          mode_writes = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;

  // Decoder state kept by the testbench.
  bit            keyboard_mode = 1'b1;
  report_bytes_t prev_keyboard = '0;
  logic [7:0]    prev_buttons = '0;

  // Generator memory so random reports often extend the previous one.
  report_bytes_t last_kbd_gen = '0;
  logic [7:0]    last_btn_gen = '0;

  hid_boot_report_to_events #(
    .KEY_SLOTS(KeySlots)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .rpt_valid(rpt_valid),
    .rpt_stall(rpt_stall),
    .rpt      (rpt),
    .evt_valid(evt_valid),
    .evt_stall(evt_stall),
    .evt      (evt),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic report_bytes_t bytes_of(report_t r);
    report_bytes_t b;
    b[0] = r.report_byte_0;
    b[1] = r.report_byte_1;
    b[2] = r.report_byte_2;
    b[3] = r.report_byte_3;
    b[4] = r.report_byte_4;
    b[5] = r.report_byte_5;
    b[6] = r.report_byte_6;
    b[7] = r.report_byte_7;
    return b;
  endfunction

  function automatic report_t report_from_bytes(report_bytes_t b, logic [6:0] len);
    report_t r;
    r.report_byte_0 = b[0];
    r.report_byte_1 = b[1];
    r.report_byte_2 = b[2];
    r.report_byte_3 = b[3];
    r.report_byte_4 = b[4];
    r.report_byte_5 = b[5];
    r.report_byte_6 = b[6];
    r.report_byte_7 = b[7];
    r.report_length = len;
    return r;
  endfunction

  function automatic report_t make_report(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                          logic [7:0] b3, logic [7:0] b4, logic [7:0] b5,
                                          logic [7:0] b6, logic [7:0] b7, logic [6:0] len);
    report_bytes_t b;
    b = {b7, b6, b5, b4, b3, b2, b1, b0};
    return report_from_bytes(b, len);
  endfunction

  // True when any active key slot of the report holds the usage.
  function automatic bit slot_holds(report_bytes_t b, logic [7:0] usage);
    for (int s = 0; s < SlotsUsed; s++) begin
      if (b[SlotBase + s] == usage) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Full-length keyboard reports without a rollover marker are decoded.
  function automatic bit keyboard_report_decoded(report_t r);
    return (r.report_length >= ReportBytes) && !slot_holds(bytes_of(r), RolloverUsage);
  endfunction

  function automatic event_t make_event(logic [1:0] typ, logic [8:0] code, logic [7:0] value);
    event_t e;
    e.event_type    = typ;
    e.event_code    = code;
    e.event_value   = value;
    e.last_of_burst = 1'b0;
    return e;
  endfunction

  // Works out the burst of events one accepted report causes and updates
  // the stored report of the active mode.
  function automatic void decode_report(report_t r);
    report_bytes_t cur;
    event_t        burst[$];
    event_t        e;
    logic [7:0]    diff;
    cur = bytes_of(r);
    if (keyboard_mode) begin
      if (keyboard_report_decoded(r)) begin
        // Modifier changes from bit 0 up, then releases, then presses.
        diff = prev_keyboard[0] ^ cur[0];
        for (int b = 0; b < 8; b++) begin
          if (diff[b]) burst.push_back(make_event(EvKey, ModUsageBase + 9'(b), {7'd0, cur[0][b]}));
        end
        for (int s = 0; s < SlotsUsed; s++) begin
          if (prev_keyboard[SlotBase + s] != EmptySlot &&
              !slot_holds(cur, prev_keyboard[SlotBase + s]))
            burst.push_back(make_event(EvKey, {1'b0, prev_keyboard[SlotBase + s]}, 8'd0));
        end
        for (int s = 0; s < SlotsUsed; s++) begin
          if (cur[SlotBase + s] != EmptySlot && !slot_holds(prev_keyboard, cur[SlotBase + s]))
            burst.push_back(make_event(EvKey, {1'b0, cur[SlotBase + s]}, 8'd1));
        end
        prev_keyboard = cur;
      end
    end else if (r.report_length >= MouseMinLen) begin
      // Left, right and middle use consecutive codes; the whole byte is kept.
      diff = prev_buttons ^ cur[0];
      for (int i = 0; i < MouseBtns; i++) begin
        if (diff[i]) burst.push_back(make_event(EvKey, CodeBtnLeft + 9'(i), {7'd0, cur[0][i]}));
      end
      prev_buttons = cur[0];
      if (cur[1] != 8'd0) burst.push_back(make_event(EvRel, CodeRelX, cur[1]));
      if (cur[2] != 8'd0) burst.push_back(make_event(EvRel, CodeRelY, cur[2]));
      if (r.report_length > MouseMinLen && cur[3] != 8'd0)
        burst.push_back(make_event(EvRel, CodeRelWheel, cur[3]));
    end
    // A nonempty burst closes with a sync event carrying the last flag.
    if (burst.size() > 0) begin
      burst.push_back(make_event(EvSync, 9'd0, 8'd0));
      foreach (burst[i]) begin
        e = burst[i];
        e.last_of_burst = (i == burst.size() - 1);
        predicted_events.push_back(e);
      end
    end
  endfunction

  // Gap lengths: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned k;
    k = $urandom_range(99, 0);
    if (k < 60) return 0;
    if (k < 90) return $urandom_range(3, 1);
    if (k < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  // Empty slot, a key from a small shared pool, or any other usage.
  function automatic logic [7:0] random_usage();
    int unsigned k;
    k = $urandom_range(9, 0);
    if (k < 4) return EmptySlot;
    if (k < 8) return 8'($urandom_range(11, 4));
    return 8'($urandom_range(255, 2));
  endfunction

  function automatic report_t random_keyboard_report();
    report_bytes_t b;
    int unsigned   k;
    logic [6:0]    len;
    k = $urandom_range(99, 0);
    len = ($urandom_range(4, 0) == 0) ? 7'($urandom_range(64, 8)) : 7'(ReportBytes);
    if (k < 8) begin
      // Noise: any bytes and any length.
      b = {$urandom, $urandom};
      len = 7'($urandom_range(64, 0));
    end else begin
      if ($urandom_range(2, 0) == 0) begin
        // Small step from the previous report: one slot and maybe a modifier.
        b = last_kbd_gen;
        b[SlotBase + $urandom_range(SlotsUsed - 1, 0)] = random_usage();
        if ($urandom_range(1, 0) == 1) b[0][$urandom_range(7, 0)] ^= 1'b1;
      end else begin
        b[0] = ($urandom_range(3, 0) == 0) ? 8'($urandom) : last_kbd_gen[0];
        for (int s = 0; s < AvailSlots; s++) b[SlotBase + s] = random_usage();
      end
      b[1] = 8'($urandom);
      // Some well-formed reports carry the rollover marker in one slot.
      if (k < 14) b[SlotBase + $urandom_range(SlotsUsed - 1, 0)] = RolloverUsage;
      else last_kbd_gen = b;
    end
    return report_from_bytes(b, len);
  endfunction

  function automatic report_t random_mouse_report();
    report_bytes_t b;
    int unsigned   k;
    logic [6:0]    len;
    b = {$urandom, $urandom};
    k = $urandom_range(99, 0);
    if (k < 10) begin
      len = 7'($urandom_range(MouseMinLen - 1, 0));
    end else begin
      if ($urandom_range(1, 0) == 1) b[0] = last_btn_gen ^ (8'd1 << $urandom_range(7, 0));
      last_btn_gen = b[0];
      if ($urandom_range(1, 0) == 1) b[1] = 8'd0;
      if ($urandom_range(1, 0) == 1) b[2] = 8'd0;
      if ($urandom_range(1, 0) == 1) b[3] = 8'd0;
      case ($urandom_range(3, 0))
        0: len = 7'(MouseMinLen);
        1: len = 7'(MouseMinLen + 1);
        2: len = 7'(ReportBytes);
        default: len = 7'($urandom_range(64, MouseMinLen));
      endcase
    end
    return report_from_bytes(b, len);
  endfunction

  // Queues random reports until the wanted number will actually be decoded.
  task automatic queue_random(input int unsigned wanted, input bit kbd);
    int unsigned useful;
    report_t     r;
    useful = 0;
    while (useful < wanted) begin
      r = kbd ? random_keyboard_report() : random_mouse_report();
      report_queue.push_back(r);
      if (kbd ? keyboard_report_decoded(r) : (r.report_length >= MouseMinLen)) useful++;
    end
  endtask

  // Sender holds off until every expected event has arrived, then lets the
  // block settle on reports that caused no event.
  task automatic wait_until_drained();
    while (report_queue.size() != 0 || rpt_valid || predicted_events.size() != 0)
      @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // APB write of the mode register: setup cycle, then access until pready.
  task automatic write_mode(input bit kbd);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ModeRegAddr;
    pwdata  <= {31'd0, kbd};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    keyboard_mode = kbd;
    mode_writes++;
    @(negedge clk);
  endtask

  // Report driver: predicts on each accepted transaction, holds a stalled one.
  always @(posedge clk) begin
    if (rst) begin
      rpt_valid <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (rpt_valid && !rpt_stall) begin
        decode_report(rpt);
        if (keyboard_mode) keyboard_reports++;
        else mouse_reports++;
      end
      if (rpt_valid && rpt_stall) begin
        rpt_valid <= 1'b1;
      end else if (send_gap > 0) begin
        rpt_valid <= 1'b0;
        send_gap  <= send_gap - 1;
      end else if (report_queue.size() > 0) begin
        rpt       <= report_queue.pop_front();
        rpt_valid <= 1'b1;
        send_gap  <= idle_on ? pick_gap() : 0;
      end else begin
        rpt_valid <= 1'b0;
      end
    end
  end

  // Event monitor: checks each accepted transaction and applies random stalls.
  always @(posedge clk) begin
    event_t want;
    if (rst) begin
      evt_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (evt_valid && !evt_stall) begin
        events_checked++;
        if (predicted_events.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported)
            $display("Unexpected event at cycle %0d: type %0d code 0x%0h value %0d last %0b",
                     cycle_count, evt.event_type, evt.event_code, $signed(evt.event_value),
                     evt.last_of_burst);
        end else begin
          want = predicted_events.pop_front();
          if (evt.event_type !== want.event_type || evt.event_code !== want.event_code ||
              evt.event_value !== want.event_value ||
              evt.last_of_burst !== want.last_of_burst) begin
            mismatch_count++;
            if (mismatch_count <= MaxReported)
              $display({"Event mismatch at cycle %0d: expected type %0d code 0x%0h ",
                        "value %0d last %0b, got type %0d code 0x%0h value %0d last %0b"},
                       cycle_count, want.event_type, want.event_code,
                       $signed(want.event_value), want.last_of_burst, evt.event_type,
                       evt.event_code, $signed(evt.event_value), evt.last_of_burst);
          end
        end
      end
      if (stall_left > 0) begin
        evt_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        evt_stall  <= 1'b0;
        stall_left <= idle_on ? pick_gap() : 0;
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Timeout after %0d cycles", cycle_count);
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus: directed keyboard and mouse reports, then random phases.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Keyboard mode out of reset.
    // All modifiers and six keys pressed at once.
    report_queue.push_back(make_report(8'hFF, 8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 7'd8));
    // Modifiers released, most keys replaced, top usages pressed.
    report_queue.push_back(make_report(8'h00, 8'h00, 8'h0A, 8'h05, 8'h00, 8'h00, 8'hFF, 8'hE3, 7'd8));
    report_queue.push_back(make_report(8'hFF, 8'h00, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 7'd8));
    // Longest burst: eight modifier changes, six releases, six presses.
    report_queue.push_back(make_report(8'h00, 8'h00, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 7'd8));
    // Rollover marker in the last slot, then short reports: all ignored.
    report_queue.push_back(make_report(8'hAA, 8'h00, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h01, 7'd8));
    report_queue.push_back(make_report(8'h55, 8'h00, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 7'd7));
    report_queue.push_back(make_report(8'h55, 8'h00, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 7'd0));
    // Unchanged report causes no event.
    report_queue.push_back(make_report(8'h00, 8'h00, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 7'd8));
    // Same usage in two slots, long report with a busy reserved byte.
    report_queue.push_back(make_report(8'h00, 8'hFF, 8'h30, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 7'd64));
    report_queue.push_back(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 7'd8));
    wait_until_drained();

    // Mouse mode.
    write_mode(1'b0);
    // All buttons down, extreme deltas, wheel counted with four bytes.
    report_queue.push_back(make_report(8'hFF, 8'h7F, 8'h80, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 7'd4));
    // Low button bits released; the wheel byte is ignored at length three.
    report_queue.push_back(make_report(8'hF8, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 7'd3));
    // Only high button bits change: no event.
    report_queue.push_back(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 7'd8));
    // Too short to decode.
    report_queue.push_back(make_report(8'h07, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 7'd2));
    report_queue.push_back(make_report(8'h02, 8'hFF, 8'h01, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 7'd64));
    report_queue.push_back(make_report(8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 7'd4));
    wait_until_drained();

    // Random keyboard phase with no idling on either side; the stored
    // keyboard report survives the mouse phase.
    write_mode(1'b1);
    idle_on = 1'b0;
    queue_random(40, 1'b1);
    wait_until_drained();

    idle_on = 1'b1;
    write_mode(1'b0);
    queue_random(45, 1'b0);
    wait_until_drained();

    write_mode(1'b1);
    queue_random(50, 1'b1);
    wait_until_drained();

    $display("Covered %0d keyboard and %0d mouse reports, %0d events checked, %0d mode writes.",
             keyboard_reports, mouse_reports, events_checked, mode_writes);
    if (predicted_events.size() != 0)
      $display("%0d expected events never arrived", predicted_events.size());
    if (mismatch_count == 0 && predicted_events.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/hbr_pkg.sv
rtl/hbr_front.sv
rtl/hbr_queue.sv
rtl/hbr_back.sv
rtl/hid_boot_report_to_events.sv
rtl/hbr_checker.sv
sim/tb_hid_boot_report_to_events.sv
